>>> rtl/core/joint_setpoint_slew_limiter_unit_defines.svh
// Assertion macros shared by the slew limiter RTL.
// Depends on nothing; included by files that check their own logic.
`ifndef JOINT_SETPOINT_SLEW_LIMITER_UNIT_DEFINES_SVH
`define JOINT_SETPOINT_SLEW_LIMITER_UNIT_DEFINES_SVH

// Check that a condition implies a property on the same edge.
`define JSL_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");

// Check that a condition implies a property on the next edge.
`define JSL_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");

`endif

>>> rtl/core/jsl_pkg.sv
// Package for the joint slew limiter: codes, types and sizes.
// Depends on nothing; used by the top, front and back modules.
package jsl_pkg;

    localparam int unsigned JointsDefault = 16;
    localparam logic [31:0] PeriodReset   = 32'd655;
    localparam int unsigned QueueDepth    = 2;

    typedef enum logic [2:0] {
        OP_TARGET = 3'd0,
        OP_ESTOP  = 3'd1,
        OP_STOP   = 3'd2,
        OP_RESET  = 3'd3,
        OP_TICK   = 3'd4,
        OP_LOAD   = 3'd5,
        OP_BAD6   = 3'd6,
        OP_BAD7   = 3'd7
    } t_op;

    localparam logic [2:0] KIND_SETPOINT = 3'd0;
    localparam logic [2:0] KIND_ESTOP    = 3'd1;
    localparam logic [2:0] KIND_STOP     = 3'd2;
    localparam logic [2:0] KIND_RESET    = 3'd3;
    localparam logic [2:0] KIND_STATUS   = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SAFETY   = 2'd1;
    localparam logic [1:0] ST_FAULT    = 2'd2;

    localparam logic [1:0] SAFE_READY  = 2'd0;
    localparam logic [1:0] SAFE_ESTOP  = 2'd1;
    localparam logic [1:0] SAFE_FAULT  = 2'd2;
    localparam logic [1:0] SAFE_STOPPING = 2'd3;

    localparam logic [1:0] MODE_POS = 2'd0;
    localparam logic [1:0] MODE_VEL = 2'd1;
    localparam logic [1:0] MODE_EFF = 2'd2;

    // One command as it crosses the queue from front to back.
    typedef struct packed {
        t_op         op;
        logic [5:0]  joint;
        logic [1:0]  mode;
        logic [31:0] value;
        logic [30:0] rate;
        logic [30:0] effort;
        logic [31:0] measured;
        logic [31:0] lower;
        logic [31:0] upper;
        logic [30:0] lim_effort;
    } t_cmd;

    // Queue status reported by the front.
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

>>> rtl/core/joint_setpoint_slew_limiter_unit.sv
// Top level of the joint setpoint slew limiter.
// Depends on jsl_pkg, jsl_front and jsl_back.
//
// channel   direction  handshake
// command   in         start and not busy
// result    out        o_strobe, one cycle, cannot stall
// config    in         i_cfg_valid and o_cfg_ready
//
// A command passes the back states S_IDLE (pop), S_READ and S_EXEC; its
// result word is then registered onto the outputs. A tick takes S_IDLE,
// S_READ, then S_SCAN, S_TRD, S_TMUL and S_TOUT per active joint (S_SCAN
// alone with none), for the table read and registered rate*period multiply.
// The queue holds two commands; busy rises while it is full. The receiver
// cannot stall. The period is written only while the block is empty.
// Reset clears the safety state, active joints and the queue.
module joint_setpoint_slew_limiter_unit #(
    parameter int unsigned Joints = jsl_pkg::JointsDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_operation,
    input  logic [5:0]  i_joint,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_target_value,
    input  logic [30:0] i_max_rate,
    input  logic [30:0] i_max_effort,
    input  logic [31:0] i_measured_position,
    input  logic [31:0] i_lower_limit,
    input  logic [31:0] i_upper_limit,
    input  logic [30:0] i_limit_effort,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data,
    output logic        o_strobe,
    output logic [2:0]  o_kind,
    output logic [5:0]  o_out_joint,
    output logic [1:0]  o_out_mode,
    output logic [31:0] o_setpoint,
    output logic [1:0]  o_status,
    output logic [1:0]  o_safety,
    output logic        o_last
);
    import jsl_pkg::*;

    logic [31:0] r_period;
    t_cmd        cmd_in, cmd_q;
    t_qstat      qstat;
    logic        pop, idle;

    assign cmd_in = '{op: t_op'(i_operation), joint: i_joint, mode: i_mode,
        value: i_target_value, rate: i_max_rate, effort: i_max_effort,
        measured: i_measured_position, lower: i_lower_limit,
        upper: i_upper_limit, lim_effort: i_limit_effort};
    assign busy = qstat.full;

    // Period register, writable only while no command is in flight.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PeriodReset;
        end else begin
            if (i_cfg_valid && o_cfg_ready) r_period <= i_cfg_data;
        end
    end
    assign o_cfg_ready = idle;

    jsl_front u_front (
        .i_clk, .i_rst_n, .i_push(start && !busy), .i_cmd(cmd_in),
        .i_pop(pop), .o_cmd(cmd_q), .o_stat(qstat));

    jsl_back #(.Joints(Joints)) u_back (
        .i_clk, .i_rst_n, .i_have(!qstat.empty),
        .i_cmd(cmd_q), .i_period(r_period), .o_pop(pop), .o_idle(idle),
        .o_valid(o_strobe), .o_kind, .o_joint(o_out_joint), .o_mode(o_out_mode),
        .o_setpoint, .o_status, .o_safety, .o_last);
endmodule

>>> rtl/core/jsl_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
// Depends on nothing.
module jsl_ram #(
    parameter int unsigned Width = 32,
    parameter int unsigned Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/core/jsl_front.sv
// Front of the slew limiter: takes commands and queues them for the back.
// Depends on jsl_pkg.
module jsl_front #(
    parameter int unsigned Depth = jsl_pkg::QueueDepth
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  jsl_pkg::t_cmd  i_cmd,
    input  logic           i_pop,
    output jsl_pkg::t_cmd  o_cmd,
    output jsl_pkg::t_qstat o_stat
);
    import jsl_pkg::*;

    localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

    t_cmd           r_q [Depth];
    logic [AW-1:0]  r_wp, n_wp, r_rp, n_rp;
    logic [AW:0]    r_cnt, n_cnt;

    // Pointer and fill count updates; ops 6 and 7 are mapped to no change later.
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == AW'(Depth - 1)) ? '0 : r_wp + 1'b1;
        end
        if (i_pop) begin
            n_rp = (r_rp == AW'(Depth - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

    assign o_cmd        = r_q[r_rp];
    assign o_stat.full  = (r_cnt == (AW+1)'(Depth));
    assign o_stat.empty = (r_cnt == '0);
endmodule

>>> rtl/core/jsl_back.sv
// Back of the slew limiter: runs one queued command, emits its results.
// Depends on jsl_pkg, jsl_ram and the assertion macro header.
`include "joint_setpoint_slew_limiter_unit_defines.svh"
module jsl_back #(
    parameter int unsigned Joints = jsl_pkg::JointsDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_have,
    input  jsl_pkg::t_cmd       i_cmd,
    input  logic [31:0]         i_period,
    output logic                o_pop,
    output logic                o_idle,
    output logic                o_valid,
    output logic [2:0]          o_kind,
    output logic [5:0]          o_joint,
    output logic [1:0]          o_mode,
    output logic [31:0]         o_setpoint,
    output logic [1:0]          o_status,
    output logic [1:0]          o_safety,
    output logic                o_last
);
    import jsl_pkg::*;

    localparam int unsigned JW = (Joints > 1) ? $clog2(Joints) : 1;
    // Goal entry: mode, goal, rate.
    localparam int unsigned GW = 2 + 32 + 31;
    localparam int unsigned LW = 32 + 32 + 31;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_READ  = 7'b0000010,
        S_EXEC  = 7'b0000100,
        S_SCAN  = 7'b0001000,
        S_TRD   = 7'b0010000,
        S_TMUL  = 7'b0100000,
        S_TOUT  = 7'b1000000
    } t_state;

    t_state        r_st, n_st;
    t_cmd          r_cmd;
    logic [1:0]    r_safety;
    logic [Joints-1:0] r_active;
    logic [JW-1:0] r_j;

    // Memory ports.
    logic          goal_we, ref_we, lim_we;
    logic [JW-1:0] goal_wa, ref_wa, lim_wa, rd_a;
    logic [GW-1:0] goal_wd, goal_rd;
    logic [31:0]   ref_wd, ref_rd;
    logic [LW-1:0] lim_wd, lim_rd;

    jsl_ram #(.Width(GW), .Depth(Joints)) u_goal (
        .i_clk, .i_we(goal_we), .i_waddr(goal_wa), .i_wdata(goal_wd),
        .i_raddr(rd_a), .o_rdata(goal_rd));
    jsl_ram #(.Width(32), .Depth(Joints)) u_ref (
        .i_clk, .i_we(ref_we), .i_waddr(ref_wa), .i_wdata(ref_wd),
        .i_raddr(rd_a), .o_rdata(ref_rd));
    jsl_ram #(.Width(LW), .Depth(Joints)) u_lim (
        .i_clk, .i_we(lim_we), .i_waddr(lim_wa), .i_wdata(lim_wd),
        .i_raddr(rd_a), .o_rdata(lim_rd));

    // Decoded read data.
    logic [1:0]  g_mode;
    logic signed [31:0] g_goal;
    logic [30:0] g_rate;
    logic signed [31:0] l_low, l_up;
    logic [30:0] l_eff;
    assign g_mode = goal_rd[GW-1 -: 2];
    assign g_goal = goal_rd[62:31];
    assign g_rate = goal_rd[30:0];
    assign l_low  = lim_rd[LW-1 -: 32];
    assign l_up   = lim_rd[62:31];
    assign l_eff  = lim_rd[30:0];

    // Command fields.
    logic               j_ok;
    logic [JW-1:0]      cj;
    logic signed [31:0] cval;
    logic [31:0]        cmag;
    logic               viol, eff_clamp;
    logic signed [31:0] eff_val;
    always_comb begin
        j_ok = (r_cmd.joint < 7'(Joints));
        cj   = r_cmd.joint[JW-1:0];
        cval = r_cmd.value;
        cmag = cval[31] ? 32'(-cval) : cval;
        viol = ((r_cmd.mode == MODE_POS) && (cval < l_low || cval > l_up))
            || ((r_cmd.mode == MODE_EFF) && (l_eff != '0) && (cmag > {1'b0, l_eff}));
        eff_clamp = (r_cmd.mode == MODE_EFF) && (r_cmd.effort != '0)
            && (cmag > {1'b0, r_cmd.effort});
        eff_val = cval[31] ? -$signed({1'b0, r_cmd.effort}) : $signed({1'b0, r_cmd.effort});
    end

    // Tick datapath: step product registered, then clamp and emit.
    logic [62:0] r_prod;
    logic [62:0] prod_full;
    assign prod_full = 63'(g_rate) * 63'(i_period);
    logic signed [33:0] maxd, diff, step;
    logic signed [31:0] tick_val, new_ref;
    always_comb begin
        // A step beyond any possible distance saturates; it never clamps.
        maxd = (r_prod[62:49] != '0) ? 34'sh1_FFFF_FFFF : $signed({1'b0, r_prod[48:16]});
        diff = 34'(g_goal) - 34'($signed(ref_rd));
        step = diff;
        if (diff > maxd) step = maxd;
        if (diff < -maxd) step = -maxd;
        new_ref = (g_rate != '0) ? 32'(34'($signed(ref_rd)) + step) : g_goal;
        tick_val = g_goal;
        if (g_mode == MODE_POS) begin
            tick_val = new_ref;
        end else if (g_mode == MODE_VEL && g_rate != '0) begin
            if (g_goal > $signed({1'b0, g_rate})) tick_val = $signed({1'b0, g_rate});
            if (g_goal < -$signed({1'b0, g_rate})) tick_val = -$signed({1'b0, g_rate});
        end
    end

    // Find next active joint at or after r_j.
    logic          more;
    logic [JW-1:0] next_j;
    logic          more_after;
    always_comb begin
        more = 1'b0;
        next_j = '0;
        for (int i = Joints - 1; i >= 0; i--) begin
            if (r_active[i] && JW'(i) >= r_j) begin
                more = 1'b1;
                next_j = JW'(i);
            end
        end
        more_after = 1'b0;
        for (int i = 0; i < Joints; i++) begin
            if (r_active[i] && JW'(i) > r_j) more_after = 1'b1;
        end
    end

    // Result register and control.
    logic        n_valid, n_last;
    logic [2:0]  n_kind;
    logic [5:0]  n_joint;
    logic [1:0]  n_mode, n_status, n_safety;
    logic [31:0] n_setp;
    logic [Joints-1:0] n_active;
    logic [JW-1:0] n_j;

    always_comb begin
        n_st = r_st; n_j = r_j; n_active = r_active; n_safety = r_safety;
        n_valid = 1'b0; n_last = 1'b1; n_kind = KIND_STATUS; n_joint = '0;
        n_mode = '0; n_setp = '0; n_status = ST_OK;
        o_pop = 1'b0;
        goal_we = 1'b0; ref_we = 1'b0; lim_we = 1'b0;
        goal_wa = cj; ref_wa = cj; lim_wa = cj;
        goal_wd = {r_cmd.mode, (eff_clamp ? eff_val : cval), r_cmd.rate};
        ref_wd  = r_cmd.measured;
        lim_wd  = {r_cmd.lower, r_cmd.upper, r_cmd.lim_effort};
        rd_a    = cj;
        unique case (r_st)
            S_IDLE: if (i_have) begin
                o_pop = 1'b1;
                n_st = S_READ;
            end
            S_READ: begin
                n_st = S_EXEC;
                if (r_cmd.op == OP_TICK) begin
                    n_j = '0;
                    n_st = S_SCAN;
                end
            end
            S_EXEC: begin
                n_valid = 1'b1;
                n_st = S_IDLE;
                unique case (r_cmd.op)
                    OP_TARGET: begin
                        if (!j_ok || r_cmd.mode == 2'd3) begin
                            n_status = ST_OK;
                        end else if (r_safety == SAFE_ESTOP || r_safety == SAFE_FAULT) begin
                            n_status = ST_SAFETY;
                        end else if (viol) begin
                            n_active = '0; n_safety = SAFE_FAULT; n_status = ST_FAULT;
                        end else begin
                            goal_we = 1'b1;
                            ref_we = (r_cmd.mode == MODE_POS)
                                && (!r_active[cj] || g_mode != MODE_POS);
                            n_active[cj] = 1'b1;
                            n_safety = SAFE_READY;
                        end
                    end
                    OP_ESTOP: begin
                        n_active = '0; n_safety = SAFE_ESTOP; n_kind = KIND_ESTOP;
                    end
                    OP_STOP: begin
                        if (r_safety == SAFE_ESTOP || r_safety == SAFE_FAULT) begin
                            n_status = ST_SAFETY;
                        end else begin
                            n_active = '0; n_safety = SAFE_STOPPING; n_kind = KIND_STOP;
                        end
                    end
                    OP_RESET: begin
                        n_active = '0; n_safety = SAFE_READY; n_kind = KIND_RESET;
                    end
                    OP_LOAD: lim_we = (r_active == '0) && j_ok;
                    default: ;
                endcase
            end
            S_SCAN: begin
                if (more) begin
                    n_j = next_j;
                    rd_a = next_j;
                    n_st = S_TRD;
                end else begin
                    n_st = S_IDLE;
                end
            end
            S_TRD: begin
                rd_a = r_j;
                n_st = S_TMUL;
            end
            S_TMUL: begin
                rd_a = r_j;
                n_st = S_TOUT;
            end
            S_TOUT: begin
                rd_a = r_j;
                n_valid = 1'b1;
                n_kind = KIND_SETPOINT;
                n_joint = 6'(r_j);
                n_mode = g_mode;
                n_setp = tick_val;
                n_last = !more_after;
                ref_wa = r_j;
                ref_wd = new_ref;
                ref_we = (g_mode == MODE_POS);
                if (more_after) begin
                    n_j = r_j + 1'b1;
                    n_st = S_SCAN;
                end else begin
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    logic        r_valid, r_last;
    logic [2:0]  r_kind;
    logic [5:0]  r_joint;
    logic [1:0]  r_mode, r_status, r_osafe;
    logic [31:0] r_setp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_safety <= SAFE_READY; r_active <= '0;
            r_j <= '0; r_valid <= 1'b0;
        end else begin
            r_st <= n_st; r_safety <= n_safety; r_active <= n_active;
            r_j <= n_j; r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_cmd <= i_cmd;
        r_prod <= prod_full;
        r_last <= n_last; r_kind <= n_kind; r_joint <= n_joint; r_mode <= n_mode;
        r_status <= n_status; r_osafe <= n_safety; r_setp <= n_setp;
    end

    assign o_valid = r_valid;
    assign o_last = r_last; assign o_kind = r_kind; assign o_joint = r_joint;
    assign o_mode = r_mode; assign o_status = r_status; assign o_safety = r_osafe;
    assign o_setpoint = r_setp;
    assign o_idle = (r_st == S_IDLE) && !i_have;

    `JSL_ASSERT_IMP(a_fault_clears, i_clk, i_rst_n, r_safety == SAFE_FAULT, r_active == '0)
    `JSL_ASSERT_NEXT(a_exec_emits, i_clk, i_rst_n, r_st == S_EXEC, r_valid)
    `JSL_ASSERT_NEXT(a_pop_reads, i_clk, i_rst_n, o_pop, r_st == S_READ)
endmodule
